>>> rtl/mas_pkg.sv
// package for the middle access stack: sizes, request and status codes, fsm states
package mas_pkg;
  localparam int unsigned Depth = 16;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP = 2'd1;
  localparam logic [1:0] REQ_DEL_MID = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [DataW-1:0] NoneValue = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POPRD,
    S_SHRD,
    S_SHWR,
    S_MIDRD,
    S_MIDWT,
    S_OUT
  } state_e;
endpackage

>>> rtl/middle_access_stack_unit.sv
// top level of the middle access stack
// Bounded stack of 16 signed 32-bit entries held in one single-port ram with
// registered read. One request at a time: push writes the new top entry, pop
// reads the top entry, delete-middle moves each entry above the middle down by
// one (a read and a write per entry moved), each request ending with a read of
// the new middle entry. Rejected, no-op and delete requests that move nothing
// go straight to that middle read.
// in_stall_o stays high until the result has been transferred out; out_valid_o
// holds the result for as long as out_stall_i is high.
module middle_access_stack_unit
  import mas_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [DataW-1:0] push_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] popped_value_o,
  output logic                    middle_valid_o,
  output logic signed [DataW-1:0] middle_value_o,
  output logic [4:0]              entry_count_o
);
  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [1:0] status_q, status_d;
  logic [DataW-1:0] popped_q, popped_d;
  logic [DataW-1:0] mid_q, mid_d;
  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  mas_ram #(.Width(DataW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // state and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    status_q <= status_d;
    popped_q <= popped_d;
    mid_q <= mid_d;
  end

  // sequencer: push write, pop read, shift and middle lookup through the ram port
  always_comb begin
    logic [CntW-1:0] mid_pos;
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    status_d = status_q;
    popped_d = popped_q;
    mid_d = mid_q;
    ram_we = 1'b0;
    ram_addr = idx_q;
    ram_wdata = push_value_i;
    mid_pos = cnt_q >> 1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_DONE;
          popped_d = NoneValue;
          state_d = S_MIDRD;
          case (req_type_i)
            REQ_PUSH: begin
              if (cnt_q >= CntW'(Depth)) begin
                status_d = ST_FULL;
              end else begin
                ram_we = 1'b1;
                ram_addr = cnt_q[AddrW-1:0];
                cnt_d = cnt_q + 1'b1;
              end
            end
            REQ_POP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                ram_addr = AddrW'(cnt_q - 1'b1);
                idx_d = AddrW'(cnt_q - 1'b1);
                state_d = S_POPRD;
              end
            end
            REQ_DEL_MID: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else if (CntW'(mid_pos + 1'b1) >= cnt_q) begin
                cnt_d = cnt_q - 1'b1;
              end else begin
                idx_d = AddrW'(mid_pos + 1'b1);
                state_d = S_SHRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POPRD: begin
        // top entry was read at the accepting edge and lands now
        state_d = S_MIDRD;
        popped_d = ram_rdata;
        cnt_d = cnt_q - 1'b1;
      end
      S_SHRD: begin
        // read of entry idx_q lands next cycle
        state_d = S_SHWR;
      end
      S_SHWR: begin
        ram_we = 1'b1;
        ram_addr = idx_q - 1'b1;
        ram_wdata = ram_rdata;
        if (CntW'(idx_q) + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          state_d = S_MIDRD;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_SHRD;
        end
      end
      S_MIDRD: begin
        ram_addr = mid_pos[AddrW-1:0];
        state_d = S_MIDWT;
      end
      S_MIDWT: begin
        mid_d = (cnt_q == '0) ? NoneValue : ram_rdata;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o = status_q;
  assign popped_value_o = popped_q;
  assign middle_valid_o = (cnt_q != '0);
  assign middle_value_o = mid_q;
  assign entry_count_o = 5'(cnt_q);
endmodule

>>> rtl/mas_ram.sv
// generic single port ram with registered read
module mas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write, or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
